/* hw/rtl/cube_map_direction_to_uv_defines.svh */
// ----------------------------------------------------------------------------
// Cube map direction to UV: assertion macros
// Property wrappers clocked on clk and disabled while arst_n is low.
// They are left empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CUBE_MAP_DIRECTION_TO_UV_DEFINES_SVH
`define CUBE_MAP_DIRECTION_TO_UV_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CMUV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cube map pipeline check failed");
// next-cycle implication
`define CMUV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cube map pipeline check failed");
`else
`define CMUV_ASSERT_IMPL(lbl, ante, cons)
`define CMUV_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/cmuv_pkg.sv */
// ----------------------------------------------------------------------------
// Cube map direction to UV: shared package
// Widths, face and layout codes, in-flight item types and cross tile tables.
// ----------------------------------------------------------------------------
package cmuv_pkg;

	// field widths
	localparam int COMPONENT_BITS = 16;
	localparam int COORD_BITS     = 16;
	localparam int FACE_W         = 3;

	// numerator / denominator of the face divide: up to 2^COMPONENT_BITS
	localparam int DEN_W = COMPONENT_BITS + 1;

	// stream widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((3 * COMPONENT_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * COORD_BITS + FACE_W + 7) / 8) * 8;

	// divide by three as multiply by reciprocal: exact for x < 2^(COORD_BITS+2)
	localparam int X_W         = COORD_BITS + 2;
	localparam int RECIP_SHIFT = COORD_BITS + 4;
	localparam int RECIP_W     = COORD_BITS + 3;
	localparam int PROD_W      = X_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP3 =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);

	// face codes
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

	// image layouts; the unused code behaves as the horizontal strip
	typedef enum logic [1:0] {
		LAYOUT_HSTRIP  = 2'd0,
		LAYOUT_VSTRIP  = 2'd1,
		LAYOUT_GRID3X4 = 2'd2
	} layout_t;

	// item in the divider chain
	typedef struct packed {
		logic                  zero;
		logic [FACE_W-1:0]     face;
		logic [DEN_W-1:0]      den;
		logic [DEN_W-1:0]      rem_u;
		logic [DEN_W-1:0]      rem_v;
		logic [COORD_BITS-1:0] quo_u;
		logic [COORD_BITS-1:0] quo_v;
	} div_item_t;

	// finished result
	typedef struct packed {
		logic                  zero;
		logic [FACE_W-1:0]     face;
		logic [COORD_BITS-1:0] v;
		logic [COORD_BITS-1:0] u;
	} coord_t;

	// cross layout tile column
	function automatic logic [1:0] cross_col(input logic [FACE_W-1:0] face);
		logic [1:0] col;
		unique case (face)
			FACE_NEG_X: col = 2'd0;
			FACE_POS_X: col = 2'd2;
			FACE_NEG_Y, FACE_POS_Y, FACE_NEG_Z, FACE_POS_Z: col = 2'd1;
			default:    col = 2'd0;
		endcase
		return col;
	endfunction

	// cross layout tile row
	function automatic logic [1:0] cross_row(input logic [FACE_W-1:0] face);
		logic [1:0] row;
		unique case (face)
			FACE_NEG_X, FACE_POS_X, FACE_POS_Z: row = 2'd1;
			FACE_NEG_Y: row = 2'd2;
			FACE_POS_Y: row = 2'd0;
			FACE_NEG_Z: row = 2'd3;
			default:    row = 2'd0;
		endcase
		return row;
	endfunction

endpackage

/* hw/rtl/cmuv_classify.sv */
// ----------------------------------------------------------------------------
// Cube map direction to UV: major axis classification
// Two stages: magnitudes, then major axis, face, divide operands.
// ----------------------------------------------------------------------------
module cmuv_classify import cmuv_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      ce,
	input  logic                      in_valid,
	input  logic [COMPONENT_BITS-1:0] dir_x,
	input  logic [COMPONENT_BITS-1:0] dir_y,
	input  logic [COMPONENT_BITS-1:0] dir_z,
	output logic                      out_valid,
	output div_item_t                 out_item
);

	logic [COMPONENT_BITS-1:0] mag_x, mag_y, mag_z;
	logic                      valid_s1;
	logic [COMPONENT_BITS-1:0] vx_s1, vy_s1, vz_s1;
	logic [COMPONENT_BITS-1:0] mx_s1, my_s1, mz_s1;

	logic                      sel_x, sel_y, major_neg;
	logic [COMPONENT_BITS-1:0] am, minor_a, minor_b;
	logic [DEN_W-1:0]          ext_a, ext_b, t_a, t_b;
	div_item_t                 item_d;
	logic                      valid_s2;
	div_item_t                 item_s2;

	// stage 1: magnitudes (full negative scale fits unsigned)
	assign mag_x = dir_x[COMPONENT_BITS-1] ? (~dir_x + 1'b1) : dir_x;
	assign mag_y = dir_y[COMPONENT_BITS-1] ? (~dir_y + 1'b1) : dir_y;
	assign mag_z = dir_z[COMPONENT_BITS-1] ? (~dir_z + 1'b1) : dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			vx_s1 <= dir_x;
			vy_s1 <= dir_y;
			vz_s1 <= dir_z;
			mx_s1 <= mag_x;
			my_s1 <= mag_y;
			mz_s1 <= mag_z;
		end
	end

	// stage 2: major axis (ties to later axis), face, numerators
	always_comb begin
		sel_x = (mx_s1 > my_s1) && (mx_s1 > mz_s1);
		sel_y = !sel_x && (my_s1 > mz_s1);
		if (sel_x) begin
			major_neg   = vx_s1[COMPONENT_BITS-1];
			am          = mx_s1;
			minor_a     = vy_s1;
			minor_b     = vz_s1;
			item_d.face = major_neg ? FACE_NEG_X : FACE_POS_X;
		end else if (sel_y) begin
			major_neg   = vy_s1[COMPONENT_BITS-1];
			am          = my_s1;
			minor_a     = vz_s1;
			minor_b     = vx_s1;
			item_d.face = major_neg ? FACE_NEG_Y : FACE_POS_Y;
		end else begin
			major_neg   = vz_s1[COMPONENT_BITS-1];
			am          = mz_s1;
			minor_a     = vx_s1;
			minor_b     = vy_s1;
			item_d.face = major_neg ? FACE_NEG_Z : FACE_POS_Z;
		end

		// minor times sign of major, plus major magnitude: lands in [0, 2m]
		ext_a = {minor_a[COMPONENT_BITS-1], minor_a};
		ext_b = {minor_b[COMPONENT_BITS-1], minor_b};
		t_a   = major_neg ? (~ext_a + 1'b1) : ext_a;
		t_b   = major_neg ? (~ext_b + 1'b1) : ext_b;

		item_d.zero  = (mx_s1 == '0) && (my_s1 == '0) && (mz_s1 == '0);
		item_d.den   = {am, 1'b0};
		item_d.rem_u = t_a + {1'b0, am};
		item_d.rem_v = t_b + {1'b0, am};
		item_d.quo_u = '0;
		item_d.quo_v = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			item_s2 <= item_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

/* hw/rtl/cmuv_div_step.sv */
// ----------------------------------------------------------------------------
// Cube map direction to UV: restoring divide step
// One quotient bit for both face coordinates, registered.
// ----------------------------------------------------------------------------
module cmuv_div_step import cmuv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ce,
	input  logic      in_valid,
	input  div_item_t in_item,
	output logic      out_valid,
	output div_item_t out_item
);

	logic [DEN_W:0] r2_u, r2_v, den_x;
	logic           ge_u, ge_v;
	div_item_t      item_d;
	logic           valid_sn;
	div_item_t      item_sn;

	// shift, compare, subtract; remainder stays no greater than the divisor
	always_comb begin
		den_x = {1'b0, in_item.den};
		r2_u  = {in_item.rem_u, 1'b0};
		r2_v  = {in_item.rem_v, 1'b0};
		ge_u  = r2_u >= den_x;
		ge_v  = r2_v >= den_x;

		item_d       = in_item;
		item_d.rem_u = ge_u ? DEN_W'(r2_u - den_x) : r2_u[DEN_W-1:0];
		item_d.rem_v = ge_v ? DEN_W'(r2_v - den_x) : r2_v[DEN_W-1:0];
		item_d.quo_u = {in_item.quo_u[COORD_BITS-2:0], ge_u};
		item_d.quo_v = {in_item.quo_v[COORD_BITS-2:0], ge_v};
	end

	// stage register of this step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (ce) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			item_sn <= item_d;
		end
	end

	assign out_valid = valid_sn;
	assign out_item  = item_sn;

endmodule

/* hw/rtl/cmuv_place.sv */
// ----------------------------------------------------------------------------
// Cube map direction to UV: tile placement
// Adds the tile offset and scales for the layout; one shared divide by
// three (reciprocal multiply) per item, then the final select.
// ----------------------------------------------------------------------------
module cmuv_place import cmuv_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      ce,
	input  logic      in_valid,
	input  div_item_t in_item,
	input  logic [1:0] layout,
	output logic      out_valid,
	output coord_t    out_coord
);

	logic [X_W-1:0]        x_op;
	logic [PROD_W-1:0]     prod;
	logic                  valid_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [COORD_BITS-1:0] fu_s1, fv_s1;
	logic [FACE_W-1:0]     face_s1;
	logic                  zero_s1;
	logic [1:0]            layout_s1;
	logic [COORD_BITS-1:0] q;
	coord_t                coord_d;
	logic                  valid_s2;
	coord_t                coord_s2;

	// stage 1: offset tile and multiply by the reciprocal of three
	always_comb begin
		case (layout)
			LAYOUT_VSTRIP:  x_op = X_W'({in_item.face, in_item.quo_v} >> 1);
			LAYOUT_GRID3X4: x_op = {cross_col(in_item.face), in_item.quo_u};
			default:        x_op = X_W'({in_item.face, in_item.quo_u} >> 1);
		endcase
		prod = PROD_W'(x_op) * PROD_W'(RECIP3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			prod_s1   <= prod;
			fu_s1     <= in_item.quo_u;
			fv_s1     <= in_item.quo_v;
			face_s1   <= in_item.face;
			zero_s1   <= in_item.zero;
			layout_s1 <= layout;
		end
	end

	// stage 2: pick coordinates, clear for a zero vector
	always_comb begin
		q = prod_s1[RECIP_SHIFT +: COORD_BITS];
		case (layout_s1)
			LAYOUT_VSTRIP: begin
				coord_d.u = fu_s1;
				coord_d.v = q;
			end
			LAYOUT_GRID3X4: begin
				coord_d.u = q;
				coord_d.v = COORD_BITS'({cross_row(face_s1), fv_s1} >> 2);
			end
			default: begin
				coord_d.u = q;
				coord_d.v = fv_s1;
			end
		endcase
		coord_d.face = face_s1;
		coord_d.zero = zero_s1;
		if (zero_s1) begin
			coord_d.u    = '0;
			coord_d.v    = '0;
			coord_d.face = FACE_NEG_X;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			coord_s2 <= coord_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_coord = coord_s2;

endmodule

/* hw/rtl/cube_map_direction_to_uv.sv */
// ----------------------------------------------------------------------------
// Cube map direction to UV: top level
// Maps a direction vector to cube-map panorama texture coordinates.
// ----------------------------------------------------------------------------
// Usage:
//  s_* channel carries one direction per beat: dir_x, dir_y, dir_z, each a
//  signed Q1.15 component. m_* channel returns one result per input beat, in
//  order: tex_u, tex_v (unsigned Q0.16) and face_code in tdata, zero_vector
//  in tuser. cfg_wr_en/cfg_wr_data set face_layout (0 horizontal strip,
//  1 vertical strip, 2 cross); write it only while no beat is in flight.
//  On its way to m_tvalid an accepted beat passes two classification stages,
//  one restoring-divide stage per coordinate bit, two placement stages and
//  the output register. Throughput is one beat per cycle while s_tready is
//  high; the divider chain makes up most of the stages.
//  Reset clears every valid bit and sets face_layout to the horizontal strip;
//  no clearing pass is needed. When the receiver stalls, a skid register
//  takes one more result and then s_tready drops, freezing the pipeline
//  until the output drains; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`include "cube_map_direction_to_uv_defines.svh"

module cube_map_direction_to_uv import cmuv_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_wr_en,
	input  logic [1:0]             cfg_wr_data,  // face_layout
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,      // dir_x, dir_y, dir_z
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,      // tex_u, tex_v, face_code, pad
	output logic [0:0]             m_tuser       // zero_vector
);

	logic [1:0] layout_q;
	logic       ce;
	logic       pipe_valid;
	coord_t     pipe_coord;
	logic       out_valid_q, skid_valid_q;
	coord_t     out_q, skid_q;

	logic      div_valid [COORD_BITS+1];
	div_item_t div_item  [COORD_BITS+1];

	// layout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_HSTRIP;
		end else if (cfg_wr_en) begin
			layout_q <= cfg_wr_data;
		end
	end

	// whole pipeline advances unless the skid holds a beat
	assign ce       = !skid_valid_q;
	assign s_tready = ce;

	cmuv_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (s_tvalid),
		.dir_x     (s_tdata[0 +: COMPONENT_BITS]),
		.dir_y     (s_tdata[COMPONENT_BITS +: COMPONENT_BITS]),
		.dir_z     (s_tdata[2*COMPONENT_BITS +: COMPONENT_BITS]),
		.out_valid (div_valid[0]),
		.out_item  (div_item[0])
	);

	// one divider stage per coordinate bit
	for (genvar g = 0; g < COORD_BITS; g++) begin : g_div
		cmuv_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.ce        (ce),
			.in_valid  (div_valid[g]),
			.in_item   (div_item[g]),
			.out_valid (div_valid[g+1]),
			.out_item  (div_item[g+1])
		);
	end

	cmuv_place u_place (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (div_valid[COORD_BITS]),
		.in_item   (div_item[COORD_BITS]),
		.layout    (layout_q),
		.out_valid (pipe_valid),
		.out_coord (pipe_coord)
	);

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= pipe_valid;
			end
		end else if (pipe_valid && ce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			out_q <= skid_valid_q ? skid_q : pipe_coord;
		end else if (pipe_valid && ce) begin
			skid_q <= pipe_coord;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.face, out_q.v, out_q.u});
	assign m_tuser  = out_q.zero;

	// checks
	`CMUV_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q)
	`CMUV_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid_q), $past(out_valid_q && !m_tready))
	`CMUV_ASSERT_NEXT(a_skid_held_in_stall, skid_valid_q && !m_tready, skid_valid_q)
	`CMUV_ASSERT_IMPL(a_zero_clears, out_valid_q && out_q.zero, m_tdata == '0)

endmodule
